/* rtl/lkdf_pkg.sv */
// Shared types, constants and weight table of the dense optical flow block.
// Used by lkdf_div and lucas_kanade_dense_flow_unit; no dependencies.
`default_nettype none
package lkdf_pkg;

	// window geometry
	localparam int RADIUS   = 2;
	localparam int TAPS_1D  = 2 * RADIUS + 1;
	localparam int NROWS    = 2 * RADIUS + 3;
	localparam int DMAX     = 2 * RADIUS * RADIUS;
	localparam int TAP_W    = $clog2(TAPS_1D);
	localparam int SLOT_W   = $clog2(NROWS);
	localparam int DW       = $clog2(DMAX + 1);

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int WIDTH_CAP     = 1024;
	localparam int HEIGHT_CAP    = 4096;

	// field and register widths
	localparam int PIX_W  = 8;
	localparam int ROW_W  = 12;
	localparam int COL_W  = 10;
	localparam int FW_W   = 11;
	localparam int FH_W   = 13;
	localparam int CFG_W  = 13;
	localparam int CIDX_W = 1;
	localparam int FLOW_W = 16;
	localparam int WT_W   = 16;

	// datapath widths
	localparam int GRAD_W = PIX_W + 1;
	localparam int SQ_W   = 2 * GRAD_W;
	localparam int WP_W   = 34;
	localparam int SUM_W  = 38;
	localparam int SHIFT  = 12;
	localparam int SC_W   = SUM_W - SHIFT;
	localparam int PROD_W = 2 * SC_W;
	localparam int N_W    = PROD_W + 1;
	localparam int DEN_W  = N_W - 1;
	localparam int MAG_W  = N_W + 1;
	localparam int QUO_W  = FLOW_W - 1;
	localparam int DIV_W  = DEN_W + QUO_W - 1;
	localparam int CNT_W  = $clog2(QUO_W + 1);

	localparam logic [FLOW_W-1:0] FLOW_SAT_POS = 16'h7FFF;
	localparam logic [FLOW_W-1:0] FLOW_SAT_NEG = 16'h8000;

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	// read slots per window tap
	localparam logic [2:0] SUB_CTR = 3'd0;
	localparam logic [2:0] SUB_XP  = 3'd1;
	localparam logic [2:0] SUB_XM  = 3'd2;
	localparam logic [2:0] SUB_YP  = 3'd3;
	localparam logic [2:0] SUB_YM  = 3'd4;

	// Gaussian weights in Q0.16 by squared distance, for a radius of two
	localparam logic [WT_W-1:0] WTAB [0:DMAX] = '{
		16'd65535, 16'd57835, 16'd51039, 16'd45042, 16'd39750,
		16'd35079, 16'd30957, 16'd27319, 16'd24109
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TAPS,
		ST_DRAIN,
		ST_SCALE,
		ST_MUL,
		ST_MULW,
		ST_CHECK,
		ST_DIVU,
		ST_DIVV,
		ST_OUT
	} lkdf_state_t;

	typedef struct packed {
		logic                  start;
		logic signed [N_W-1:0] num;
		logic [DEN_W-1:0]      den;
	} lkdf_div_req_t;

	typedef struct packed {
		logic              done;
		logic [FLOW_W-1:0] quo;
	} lkdf_div_rsp_t;

	// weight of the tap at window indexes (dxi, dyi)
	function automatic logic [WT_W-1:0] weight_at(input logic [TAP_W-1:0] dxi,
			input logic [TAP_W-1:0] dyi);
		logic signed [TAP_W:0] dx;
		logic signed [TAP_W:0] dy;
		logic [DW-1:0]         d;
		dx = $signed({1'b0, dxi}) - (TAP_W + 1)'(RADIUS);
		dy = $signed({1'b0, dyi}) - (TAP_W + 1)'(RADIUS);
		d  = DW'(dx * dx + dy * dy);
		return WTAB[d];
	endfunction

endpackage
`default_nettype wire

/* rtl/lkdf_div.sv */
// Serial divider: flow = -512 * num / den, truncated toward zero, saturated.
// Depends on lkdf_pkg; one quotient bit per cycle.
`default_nettype none
module lkdf_div (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire lkdf_pkg::lkdf_div_req_t req,
	output lkdf_pkg::lkdf_div_rsp_t      rsp
);
	import lkdf_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dd_q;
	logic [QUO_W-1:0] quo_q;
	logic             sat_q;
	logic             neg_q;

	logic [N_W-1:0]   abs_num;
	logic [MAG_W-1:0] mag;
	logic             ge;

	// magnitude of twice the numerator
	always_comb begin
		abs_num = req.num[N_W-1] ? N_W'(-req.num) : N_W'(req.num);
		mag     = {abs_num, 1'b0};
		ge      = rem_q >= dd_q;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division of mag*256 by den, divisor shifted down each step
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DIV_W'({mag, 8'd0});
			dd_q  <= DIV_W'({req.den, {(QUO_W - 1){1'b0}}});
			quo_q <= '0;
			sat_q <= DIV_W'(mag) >= DIV_W'({req.den, 7'd0});
			neg_q <= !req.num[N_W-1] && (req.num != '0);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dd_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dd_q  <= dd_q >> 1;
		end
	end

	// sign and saturation
	always_comb begin
		rsp.done = done_q;
		if (sat_q) begin
			rsp.quo = neg_q ? FLOW_SAT_NEG : FLOW_SAT_POS;
		end else if (neg_q) begin
			rsp.quo = FLOW_W'(-{1'b0, quo_q});
		end else begin
			rsp.quo = {1'b0, quo_q};
		end
	end

endmodule
`default_nettype wire

/* rtl/lucas_kanade_dense_flow_unit.sv */
// Dense Lucas-Kanade flow: pixel stream in, per-pixel Q8.8 flow out.
// Depends on lkdf_pkg and lkdf_div.
//
// Usage:
//   Pixel channel (pix_valid/pix_ready) takes co-located previous and current
//   pixels in raster order. Flow channel (flow_valid/flow_ready) returns one
//   transaction per interior pixel, RADIUS+1 rows and columns behind the input.
//   Border pixels give no transaction and are taken while the unit stays idle.
//   An interior pixel goes through the window walk, bound by the single read
//   port of the line store (five reads per tap over 25 taps), then drain,
//   scaling, six serial products on one shared multiplier, and two divisions
//   in the bit-serial divider (skipped if the determinant is not positive).
//   One item is worked on at a time; the next pixel is taken as soon as the
//   result sits in the output register, even while the receiver stalls.
//   A stalled receiver holds the result and blocks the next result, and with it the input.
//   Reset returns the frame size to 640 x 480 and the counters to zero; the
//   line store is not cleared, rows are written before windows read them.
//   A write to either register restarts the frame; write only while idle.
`default_nettype none
module lucas_kanade_dense_flow_unit #(
	parameter int MAX_WIDTH = lkdf_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lkdf_pkg::CIDX_W-1:0]   cfg_index,
	input  wire logic [lkdf_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                          pix_valid,
	output logic                               pix_ready,
	input  wire logic [lkdf_pkg::PIX_W-1:0]    prev_pixel,
	input  wire logic [lkdf_pkg::PIX_W-1:0]    curr_pixel,
	output logic                               flow_valid,
	input  wire logic                          flow_ready,
	output logic [lkdf_pkg::ROW_W-1:0]         out_row,
	output logic [lkdf_pkg::COL_W-1:0]         out_col,
	output logic signed [lkdf_pkg::FLOW_W-1:0] flow_u,
	output logic signed [lkdf_pkg::FLOW_W-1:0] flow_v,
	output logic                               flat,
	output logic                               frame_last
);
	import lkdf_pkg::*;

	localparam int DEPTH = NROWS * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int WLIM  = (MAX_WIDTH < WIDTH_CAP) ? MAX_WIDTH : WIDTH_CAP;
	localparam int EDGE0 = 2 * RADIUS + 2;

	// configuration and frame counters
	logic [FW_W-1:0]   fw_q;
	logic [FH_W-1:0]   fh_q;
	logic [FW_W-1:0]   w_eff;
	logic [FH_W-1:0]   h_eff;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [SLOT_W-1:0] slot_q;

	// item context
	logic [SLOT_W-1:0] bslot_q;
	logic [COL_W-1:0]  bcol_q;
	logic [ROW_W-1:0]  tr_q;
	logic [COL_W-1:0]  tc_q;
	logic              last_q;

	lkdf_state_t state_q, state_d;
	logic        accept;
	logic        interior;
	logic        is_last;
	logic        rd_en;
	logic        last_issue;
	logic        load_out;
	logic        den_pos;

	// window walk
	logic [TAP_W-1:0] dxi_q, dyi_q;
	logic [2:0]       sub_q;
	logic [AW-1:0]    waddr, raddr;
	logic [SLOT_W:0]  back;
	logic [SLOT_W-1:0] rslot;
	logic [COL_W-1:0] rcol;

	// line store
	logic [2*PIX_W-1:0] mem [0:DEPTH-1];
	logic [2*PIX_W-1:0] rdata_s1;
	logic               rvld_s1;
	logic [2:0]         rsub_s1;
	logic [WT_W-1:0]    rw_s1;

	// tap pipeline
	logic [PIX_W-1:0]        c_q, p_q, xp_q, xm_q, yp_q;
	logic                    v_s2, v_s3, v_s4;
	logic signed [GRAD_W-1:0] gx_s2, gy_s2, it_s2;
	logic [WT_W-1:0]         w_s2, w_s3;
	logic signed [SQ_W-1:0]  xx_s3, yy_s3, xy_s3, xt_s3, yt_s3;
	logic signed [SQ_W-1:0]  xx_c, yy_c, xy_c, xt_c, yt_c;
	logic signed [WP_W-1:0]  wxx_s4, wyy_s4, wxy_s4, wxt_s4, wyt_s4;
	logic signed [SQ_W+WT_W:0] mxx, myy, mxy, mxt, myt;
	logic signed [WT_W:0]    wsig;
	logic signed [SUM_W-1:0] axx_q, ayy_q, axy_q, axt_q, ayt_q;

	// solve
	logic signed [SC_W-1:0]   sxx_q, syy_q, sxy_q, sxt_q, syt_q;
	logic [2:0]               mk_q;
	logic [2:0]               pk_s1;
	logic                     pv_s1;
	logic signed [SC_W-1:0]   ma, mb;
	logic signed [PROD_W-1:0] mprod, prod_s1, hold_q;
	logic signed [N_W-1:0]    d_q, nu_q, nv_q;
	lkdf_div_req_t            div_req;
	lkdf_div_rsp_t            div_rsp;
	logic [FLOW_W-1:0]        fu_q, fv_q;
	logic                     flat_q;

	// output register
	logic              ovld_q;
	logic [ROW_W-1:0]  orow_q;
	logic [COL_W-1:0]  ocol_q;
	logic [FLOW_W-1:0] ou_q, ov_q;
	logic              oflat_q, olast_q;

	// effective frame size
	always_comb begin
		if (fw_q > FW_W'(WLIM)) begin
			w_eff = FW_W'(WLIM);
		end else if (fw_q == '0) begin
			w_eff = FW_W'(1);
		end else begin
			w_eff = fw_q;
		end
		if (fh_q > FH_W'(HEIGHT_CAP)) begin
			h_eff = FH_W'(HEIGHT_CAP);
		end else if (fh_q == '0) begin
			h_eff = FH_W'(1);
		end else begin
			h_eff = fh_q;
		end
	end

	assign accept   = pix_valid && pix_ready;
	assign interior = (row_q >= ROW_W'(EDGE0)) && (col_q >= COL_W'(EDGE0));
	assign is_last  = ({1'b0, row_q} == h_eff - 1'b1) && ({1'b0, col_q} == w_eff - 1'b1);
	assign last_issue = (sub_q == SUB_YM) && (dxi_q == TAP_W'(TAPS_1D - 1))
		&& (dyi_q == TAP_W'(TAPS_1D - 1));
	assign den_pos  = !d_q[N_W-1] && (d_q != '0);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d       = state_q;
		pix_ready     = 1'b0;
		rd_en         = 1'b0;
		load_out      = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = nu_q;
		div_req.den   = d_q[DEN_W-1:0];
		case (state_q)
			ST_IDLE: begin
				pix_ready = 1'b1;
				if (pix_valid && interior) begin
					state_d = ST_TAPS;
				end
			end
			ST_TAPS: begin
				rd_en = 1'b1;
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!(rvld_s1 || v_s2 || v_s3 || v_s4)) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: state_d = ST_MUL;
			ST_MUL: begin
				if (mk_q == 3'd5) begin
					state_d = ST_MULW;
				end
			end
			ST_MULW: state_d = ST_CHECK;
			ST_CHECK: begin
				if (den_pos) begin
					div_req.start = 1'b1;
					state_d       = ST_DIVU;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DIVU: begin
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					div_req.num   = nv_q;
					state_d       = ST_DIVV;
				end
			end
			ST_DIVV: begin
				if (div_rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!ovld_q || flow_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration registers and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q   <= FW_W'(640);
			fh_q   <= FH_W'(480);
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_FRAME_WIDTH) begin
				fw_q <= cfg_data[FW_W-1:0];
			end else begin
				fh_q <= cfg_data[FH_W-1:0];
			end
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if ({1'b0, col_q} + 1'b1 >= w_eff) begin
				col_q <= '0;
				if ({1'b0, row_q} + 1'b1 >= h_eff) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + 1'b1;
					slot_q <= (slot_q == SLOT_W'(NROWS - 1)) ? '0 : slot_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// context of the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			bslot_q <= slot_q;
			bcol_q  <= col_q;
			tr_q    <= row_q - ROW_W'(RADIUS + 1);
			tc_q    <= col_q - COL_W'(RADIUS + 1);
			last_q  <= is_last;
		end
	end

	// window walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dxi_q <= '0;
			dyi_q <= '0;
			sub_q <= SUB_CTR;
		end else if (accept) begin
			dxi_q <= '0;
			dyi_q <= '0;
			sub_q <= SUB_CTR;
		end else if (rd_en) begin
			if (sub_q == SUB_YM) begin
				sub_q <= SUB_CTR;
				if (dxi_q == TAP_W'(TAPS_1D - 1)) begin
					dxi_q <= '0;
					dyi_q <= dyi_q + 1'b1;
				end else begin
					dxi_q <= dxi_q + 1'b1;
				end
			end else begin
				sub_q <= sub_q + 1'b1;
			end
		end
	end

	// read address: rows counted back from the row just written
	always_comb begin
		back = (SLOT_W + 1)'(TAPS_1D) - (SLOT_W + 1)'(dyi_q);
		rcol = bcol_q - COL_W'(EDGE0) + COL_W'(dxi_q) + COL_W'(1);
		case (sub_q)
			SUB_CTR: ;
			SUB_XP:  rcol = rcol + 1'b1;
			SUB_XM:  rcol = rcol - 1'b1;
			SUB_YP:  back = back - 1'b1;
			SUB_YM:  back = back + 1'b1;
			default: ;
		endcase
		if ({1'b0, bslot_q} >= back) begin
			rslot = SLOT_W'({1'b0, bslot_q} - back);
		end else begin
			rslot = SLOT_W'({1'b0, bslot_q} + (SLOT_W + 1)'(NROWS) - back);
		end
		raddr = AW'(rslot) * AW'(MAX_WIDTH) + AW'(rcol);
		waddr = AW'(slot_q) * AW'(MAX_WIDTH) + AW'(col_q);
	end

	// line store: one write, one registered read
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[waddr] <= {prev_pixel, curr_pixel};
		end
		if (rd_en) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
		end else begin
			rvld_s1 <= rd_en;
			v_s2    <= rvld_s1 && (rsub_s1 == SUB_YM);
			v_s3    <= v_s2;
			v_s4    <= v_s3;
		end
	end

	// read sideband, tap operands and gradients
	always_ff @(posedge clk) begin
		rsub_s1 <= sub_q;
		rw_s1   <= weight_at(dxi_q, dyi_q);
		if (rvld_s1) begin
			case (rsub_s1)
				SUB_CTR: begin
					c_q <= rdata_s1[PIX_W-1:0];
					p_q <= rdata_s1[2*PIX_W-1:PIX_W];
				end
				SUB_XP: xp_q <= rdata_s1[PIX_W-1:0];
				SUB_XM: xm_q <= rdata_s1[PIX_W-1:0];
				SUB_YP: yp_q <= rdata_s1[PIX_W-1:0];
				SUB_YM: begin
					gx_s2 <= $signed({1'b0, xp_q}) - $signed({1'b0, xm_q});
					gy_s2 <= $signed({1'b0, yp_q}) - $signed({1'b0, rdata_s1[PIX_W-1:0]});
					it_s2 <= $signed({1'b0, c_q}) - $signed({1'b0, p_q});
					w_s2  <= rw_s1;
				end
				default: ;
			endcase
		end
	end

	// gradient products, then weighting
	always_comb begin
		xx_c = gx_s2 * gx_s2;
		yy_c = gy_s2 * gy_s2;
		xy_c = gx_s2 * gy_s2;
		xt_c = gx_s2 * it_s2;
		yt_c = gy_s2 * it_s2;
		wsig = $signed({1'b0, w_s3});
		mxx  = xx_s3 * wsig;
		myy  = yy_s3 * wsig;
		mxy  = xy_s3 * wsig;
		mxt  = xt_s3 * wsig;
		myt  = yt_s3 * wsig;
	end

	always_ff @(posedge clk) begin
		xx_s3  <= xx_c;
		yy_s3  <= yy_c;
		xy_s3  <= xy_c;
		xt_s3  <= xt_c;
		yt_s3  <= yt_c;
		w_s3   <= w_s2;
		wxx_s4 <= mxx[WP_W-1:0];
		wyy_s4 <= myy[WP_W-1:0];
		wxy_s4 <= mxy[WP_W-1:0];
		wxt_s4 <= mxt[WP_W-1:0];
		wyt_s4 <= myt[WP_W-1:0];
	end

	// window sums
	always_ff @(posedge clk) begin
		if (accept) begin
			axx_q <= '0;
			ayy_q <= '0;
			axy_q <= '0;
			axt_q <= '0;
			ayt_q <= '0;
		end else if (v_s4) begin
			axx_q <= axx_q + SUM_W'(wxx_s4);
			ayy_q <= ayy_q + SUM_W'(wyy_s4);
			axy_q <= axy_q + SUM_W'(wxy_s4);
			axt_q <= axt_q + SUM_W'(wxt_s4);
			ayt_q <= ayt_q + SUM_W'(wyt_s4);
		end
	end

	// scale sums down, truncating toward zero
	function automatic logic signed [SC_W-1:0] scale_down(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] t;
		t = s + (s[SUM_W-1] ? SUM_W'((1 << SHIFT) - 1) : SUM_W'(0));
		return t[SUM_W-1:SHIFT];
	endfunction

	always_ff @(posedge clk) begin
		if (state_q == ST_SCALE) begin
			sxx_q <= scale_down(axx_q);
			syy_q <= scale_down(ayy_q);
			sxy_q <= scale_down(axy_q);
			sxt_q <= scale_down(axt_q);
			syt_q <= scale_down(ayt_q);
		end
	end

	// shared multiplier: determinant and both numerators
	always_comb begin
		case (mk_q)
			3'd0: begin ma = sxx_q; mb = syy_q; end
			3'd1: begin ma = sxy_q; mb = sxy_q; end
			3'd2: begin ma = syy_q; mb = sxt_q; end
			3'd3: begin ma = sxy_q; mb = syt_q; end
			3'd4: begin ma = sxx_q; mb = syt_q; end
			3'd5: begin ma = sxy_q; mb = sxt_q; end
			default: begin ma = '0; mb = '0; end
		endcase
		mprod = ma * mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mk_q  <= '0;
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= (state_q == ST_MUL);
			if (state_q == ST_MUL) begin
				mk_q <= mk_q + 1'b1;
			end else begin
				mk_q <= '0;
			end
		end
	end

	// pair up products: even one held, odd one subtracted
	always_ff @(posedge clk) begin
		prod_s1 <= mprod;
		pk_s1   <= mk_q;
		if (pv_s1) begin
			case (pk_s1)
				3'd1:    d_q  <= N_W'(hold_q) - N_W'(prod_s1);
				3'd3:    nu_q <= N_W'(hold_q) - N_W'(prod_s1);
				3'd5:    nv_q <= N_W'(hold_q) - N_W'(prod_s1);
				default: hold_q <= prod_s1;
			endcase
		end
	end

	lkdf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// flow results
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			flat_q <= !den_pos;
			fu_q   <= '0;
			fv_q   <= '0;
		end else if (state_q == ST_DIVU && div_rsp.done) begin
			fu_q <= div_rsp.quo;
		end else if (state_q == ST_DIVV && div_rsp.done) begin
			fv_q <= div_rsp.quo;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (load_out) begin
			ovld_q <= 1'b1;
		end else if (flow_ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			orow_q  <= tr_q;
			ocol_q  <= tc_q;
			ou_q    <= fu_q;
			ov_q    <= fv_q;
			oflat_q <= flat_q;
			olast_q <= last_q;
		end
	end

	assign flow_valid = ovld_q;
	assign out_row    = orow_q;
	assign out_col    = ocol_q;
	assign flow_u     = $signed(ou_q);
	assign flow_v     = $signed(ov_q);
	assign flat       = oflat_q;
	assign frame_last = olast_q;

endmodule
`default_nettype wire
